### sv/pcc_pkg.sv
`timescale 1ns / 1ps
// Package for the periodic contact counter: field widths and configuration
// register indexes. Depends on nothing; every other file uses it by scoped name.
package pcc_pkg;

  // Q16.16 position width (signed) and length/cutoff width (unsigned).
  localparam int POS_W   = 32;
  localparam int LEN_W   = 31;
  localparam int COUNT_W = 16;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LEN_W;

  // Number of spatial axes.
  localparam int NUM_AXES = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X  = 3'd0,
    CFG_BOX_Y  = 3'd1,
    CFG_BOX_Z  = 3'd2,
    CFG_HALF_X = 3'd3,
    CFG_HALF_Y = 3'd4,
    CFG_HALF_Z = 3'd5
  } cfg_idx_t;

endpackage

### sv/pcc_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one atom pair per transaction.
// Depends on pcc_pkg for field widths.
interface pcc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcc_pkg::POS_W-1:0]    first_x;
  logic signed [pcc_pkg::POS_W-1:0]    first_y;
  logic signed [pcc_pkg::POS_W-1:0]    first_z;
  logic signed [pcc_pkg::POS_W-1:0]    second_x;
  logic signed [pcc_pkg::POS_W-1:0]    second_y;
  logic signed [pcc_pkg::POS_W-1:0]    second_z;
  logic        [pcc_pkg::LEN_W-1:0]    cutoff;
  logic                                list_select;
  logic                                last_pair;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
           cutoff, list_select, last_pair,
    input  ready
  );

  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
           cutoff, list_select, last_pair,
    output ready
  );
endinterface

### sv/pcc_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one contact result per transaction.
// Depends on pcc_pkg for the count width.
interface pcc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              contact_made;
  logic [pcc_pkg::COUNT_W-1:0]       contact_count;
  logic                              list_echo;
  logic                              last_result;

  modport source (
    output valid, contact_made, contact_count, list_echo, last_result,
    input  ready
  );

  modport sink (
    input  valid, contact_made, contact_count, list_echo, last_result,
    output ready
  );
endinterface

### sv/periodic_contact_counter_unit.sv
`timescale 1ns / 1ps
// Top level of the periodic contact counter: minimum-image distance pipeline
// and running contact count. Depends on pcc_pkg, pcc_in_if and pcc_out_if.
//
//   Channel       Direction  Transaction
//   in_pairs      sink       one atom pair: two positions, cutoff, list, last
//   out_results   source     contact flag, running count, list echo, last
//   cfg_*         write      box length or half length of one axis
//
// One pair is accepted per cycle while in_pairs.ready is high. Each pair
// passes through the input register, five internal stages and the output
// register.
// The stage chain is set by the squared-distance datapath: difference,
// wrap, magnitude, square, sum, compare.
// rst_n is synchronous and active low; it clears the stage valid bits, the
// running total and the configuration registers.
// Each stage holds only while its successor is full and stalled, so the
// input keeps taking pairs until every stage is occupied.
module periodic_contact_counter_unit #(
  parameter int unsigned MAX_CONTACTS = 65535
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pcc_in_if.sink                              in_pairs,
  pcc_out_if.source                           out_results,
  input  logic                                cfg_we,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NA = pcc_pkg::NUM_AXES;
  localparam int PW = pcc_pkg::POS_W;
  localparam int LW = pcc_pkg::LEN_W;
  localparam int CW = pcc_pkg::COUNT_W;
  localparam int DW = PW + 1;          // raw difference
  localparam int WW = PW + 2;          // wrapped difference
  localparam int SW = 2 * LW;          // one square
  localparam int TW = 64;              // sum of three squares

  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_CONTACTS);

  // Configuration registers.
  logic [LW-1:0] box_len_r  [NA];
  logic [LW-1:0] half_len_r [NA];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        box_len_r[i]  <= '0;
        half_len_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (pcc_pkg::cfg_idx_t'(cfg_index))
        pcc_pkg::CFG_BOX_X:  box_len_r[0]  <= cfg_data;
        pcc_pkg::CFG_BOX_Y:  box_len_r[1]  <= cfg_data;
        pcc_pkg::CFG_BOX_Z:  box_len_r[2]  <= cfg_data;
        pcc_pkg::CFG_HALF_X: half_len_r[0] <= cfg_data;
        pcc_pkg::CFG_HALF_Y: half_len_r[1] <= cfg_data;
        pcc_pkg::CFG_HALF_Z: half_len_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain from the output backwards.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;

  assign rdy_out = !out_valid_r || out_results.ready;
  assign rdy6    = !v6_r || rdy_out;
  assign rdy5    = !v5_r || rdy6;
  assign rdy4    = !v4_r || rdy5;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;

  assign in_pairs.ready = rdy1;

  logic in_xfer;
  assign in_xfer = in_pairs.valid && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_pairs.valid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy4)    v4_r        <= v3_r;
      if (rdy5)    v5_r        <= v4_r;
      if (rdy6)    v6_r        <= v5_r;
      if (rdy_out) out_valid_r <= v6_r;
    end
  end

  // Stage 1: input register.
  logic signed [PW-1:0] s1_a_r [NA];
  logic signed [PW-1:0] s1_b_r [NA];
  logic [LW-1:0]        s1_cut_r;
  logic                 s1_sel_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_a_r[0] <= in_pairs.first_x;
      s1_a_r[1] <= in_pairs.first_y;
      s1_a_r[2] <= in_pairs.first_z;
      s1_b_r[0] <= in_pairs.second_x;
      s1_b_r[1] <= in_pairs.second_y;
      s1_b_r[2] <= in_pairs.second_z;
      s1_cut_r  <= in_pairs.cutoff;
      s1_sel_r  <= in_pairs.list_select;
      s1_last_r <= in_pairs.last_pair;
    end
  end

  // Stage 2: full-width difference first - second per axis.
  logic signed [DW-1:0] s2_d_r [NA];
  logic [LW-1:0]        s2_cut_r;
  logic                 s2_sel_r, s2_last_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      for (int i = 0; i < NA; i++) begin
        s2_d_r[i] <= DW'(s1_a_r[i]) - DW'(s1_b_r[i]);
      end
      s2_cut_r  <= s1_cut_r;
      s2_sel_r  <= s1_sel_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Stage 3: one minimum-image correction per axis.
  logic signed [WW-1:0] s3_w_nxt [NA];
  logic signed [WW-1:0] s3_w_r   [NA];
  logic [LW-1:0]        s3_cut_r;
  logic                 s3_sel_r, s3_last_r;

  always_comb begin
    logic signed [WW-1:0] dd, hh, ll;
    for (int i = 0; i < NA; i++) begin
      dd = WW'(s2_d_r[i]);
      hh = signed'({{(WW-LW){1'b0}}, half_len_r[i]});
      ll = signed'({{(WW-LW){1'b0}}, box_len_r[i]});
      if (dd > hh) begin
        s3_w_nxt[i] = dd - ll;
      end else if (dd < -hh) begin
        s3_w_nxt[i] = dd + ll;
      end else begin
        s3_w_nxt[i] = dd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      s3_w_r    <= s3_w_nxt;
      s3_cut_r  <= s2_cut_r;
      s3_sel_r  <= s2_sel_r;
      s3_last_r <= s2_last_r;
    end
  end

  // Stage 4: magnitude per axis and the per-axis cutoff check.
  logic [LW-1:0] s4_mag_nxt [NA];
  logic          s4_within_nxt;
  logic [LW-1:0] s4_mag_r   [NA];
  logic          s4_within_r;
  logic [LW-1:0] s4_cut_r;
  logic          s4_sel_r, s4_last_r;

  always_comb begin
    logic [WW-1:0] mag;
    s4_within_nxt = 1'b1;
    for (int i = 0; i < NA; i++) begin
      mag = s3_w_r[i][WW-1] ? WW'(-s3_w_r[i]) : WW'(s3_w_r[i]);
      s4_mag_nxt[i] = mag[LW-1:0];
      if (mag > {{(WW-LW){1'b0}}, s3_cut_r}) begin
        s4_within_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      s4_mag_r    <= s4_mag_nxt;
      s4_within_r <= s4_within_nxt;
      s4_cut_r    <= s3_cut_r;
      s4_sel_r    <= s3_sel_r;
      s4_last_r   <= s3_last_r;
    end
  end

  // Stage 5: squares of the three magnitudes and of the cutoff.
  logic [SW-1:0] s5_sq_r [NA];
  logic [SW-1:0] s5_cc_r;
  logic          s5_within_r, s5_sel_r, s5_last_r;

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      for (int i = 0; i < NA; i++) begin
        s5_sq_r[i] <= SW'(s4_mag_r[i]) * SW'(s4_mag_r[i]);
      end
      s5_cc_r     <= SW'(s4_cut_r) * SW'(s4_cut_r);
      s5_within_r <= s4_within_r;
      s5_sel_r    <= s4_sel_r;
      s5_last_r   <= s4_last_r;
    end
  end

  // Stage 6: squared distance.
  logic [TW-1:0] s6_sum_r;
  logic [SW-1:0] s6_cc_r;
  logic          s6_within_r, s6_sel_r, s6_last_r;

  always_ff @(posedge clk) begin
    if (rdy6 && v5_r) begin
      s6_sum_r    <= TW'(s5_sq_r[0]) + TW'(s5_sq_r[1]) + TW'(s5_sq_r[2]);
      s6_cc_r     <= s5_cc_r;
      s6_within_r <= s5_within_r;
      s6_sel_r    <= s5_sel_r;
      s6_last_r   <= s5_last_r;
    end
  end

  // Output stage: final compare and the saturating running count.
  logic          hit;
  logic          load_out;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] running_total_r;
  logic          out_made_r, out_sel_r, out_last_r;
  logic [CW-1:0] out_count_r;

  assign load_out = rdy_out && v6_r;
  assign hit      = s6_within_r && (s6_sum_r <= TW'(s6_cc_r));

  always_comb begin
    if (hit && (running_total_r < MAX_COUNT)) begin
      count_nxt = running_total_r + CW'(1);
    end else begin
      count_nxt = running_total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_total_r <= '0;
    end else if (load_out) begin
      running_total_r <= s6_last_r ? '0 : count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_made_r  <= hit;
      out_count_r <= count_nxt;
      out_sel_r   <= s6_sel_r;
      out_last_r  <= s6_last_r;
    end
  end

  assign out_results.valid         = out_valid_r;
  assign out_results.contact_made  = out_made_r;
  assign out_results.contact_count = out_count_r;
  assign out_results.list_echo     = out_sel_r;
  assign out_results.last_result   = out_last_r;

  // A reported contact always carries a nonzero count.
  a_contact_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_made_r) |-> (out_count_r != '0))
    else $error("contact reported with zero count");

  // The count never passes its saturation limit.
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r <= MAX_COUNT))
    else $error("contact count above limit");

  // A result marked last restarts the running total.
  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && s6_last_r) |=> (running_total_r == '0))
    else $error("running total not cleared after last pair");

  // Each result moves the count up by at most one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> ({1'b0, out_count_r} <= ({1'b0, $past(running_total_r)} + 17'd1)))
    else $error("contact count jumped");

endmodule

### bench/periodic_contact_counter_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for periodic_contact_counter_unit: directed corner cases,
// a long contact list and random pair lists under random idling on both channels.
// Depends on pcc_pkg, pcc_in_if, pcc_out_if and the periodic_contact_counter_unit RTL.
module periodic_contact_counter_unit_tb;

  localparam int          NUM_AXES     = pcc_pkg::NUM_AXES;
  localparam int          POS_W        = pcc_pkg::POS_W;
  localparam int          LEN_W        = pcc_pkg::LEN_W;
  localparam int          COUNT_W      = pcc_pkg::COUNT_W;
  localparam int          CFG_IDX_W    = pcc_pkg::CFG_IDX_W;
  localparam int          CFG_DATA_W   = pcc_pkg::CFG_DATA_W;
  localparam int          MAX_CONTACTS = 65535;
  localparam int          LATENCY      = 6;
  localparam int          STALL_LIMIT  = 5000;
  localparam int          ONE          = 1 << 16;
  localparam int          POS_MAX      = 32'sh7fff_ffff;
  localparam int          POS_MIN      = 32'sh8000_0000;
  localparam int unsigned LEN_MAX      = 32'h7fff_ffff;

  typedef struct packed {
    logic [NUM_AXES-1:0][POS_W-1:0] pos_a;
    logic [NUM_AXES-1:0][POS_W-1:0] pos_b;
    logic [LEN_W-1:0]               cutoff;
    logic                           list_select;
    logic                           last_pair;
  } pair_t;

  typedef struct packed {
    logic               contact_made;
    logic [COUNT_W-1:0] contact_count;
    logic               list_echo;
    logic               last_result;
  } contact_result_t;

  typedef bit [LEN_W-1:0] axis_len_t [NUM_AXES];

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcc_in_if  pair_if ();
  pcc_out_if res_if ();

  periodic_contact_counter_unit #(
    .MAX_CONTACTS(MAX_CONTACTS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pairs   (pair_if),
    .out_results(res_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow of the box registers and the running contact total.
  axis_len_t box_len;
  axis_len_t half_len;
  int        list_total;

  contact_result_t expected_contacts [$];
  int              mismatches;
  bit              src_gaps_on;
  bit              sink_stalls_on;
  contact_result_t got_result;
  contact_result_t want_result;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly short, occasionally long.
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Minimum-image distance test against the current box settings.
  function automatic bit within_cutoff(pair_t p);
    longint          d;
    longint          h;
    longint          l;
    longint unsigned mag [NUM_AXES];
    longint unsigned cut;
    longint unsigned dist_sq;
    cut = p.cutoff;
    for (int k = 0; k < NUM_AXES; k++) begin
      d = longint'($signed(p.pos_a[k])) - longint'($signed(p.pos_b[k]));
      h = half_len[k];
      l = box_len[k];
      if (d > h) begin
        d -= l;
      end else if (d < -h) begin
        d += l;
      end
      mag[k] = (d < 0) ? -d : d;
      // One axis beyond the cutoff already rules out a contact.
      if (mag[k] > cut) return 1'b0;
    end
    dist_sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    return dist_sq <= cut * cut;
  endfunction

  // Work out the result of one accepted pair and queue it.
  function automatic void predict_contact(pair_t p);
    contact_result_t r;
    r.contact_made = within_cutoff(p);
    if (r.contact_made && list_total < MAX_CONTACTS) list_total++;
    r.contact_count = list_total[COUNT_W-1:0];
    r.list_echo     = p.list_select;
    r.last_result   = p.last_pair;
    expected_contacts.push_back(r);
    if (p.last_pair) list_total = 0;
  endfunction

  function automatic pair_t make_fixed(int ax, int ay, int az, int bx, int by, int bz,
                                       int unsigned cut, bit sel, bit last);
    pair_t p;
    p.pos_a       = {az, ay, ax};
    p.pos_b       = {bz, by, bx};
    p.cutoff      = LEN_W'(cut);
    p.list_select = sel;
    p.last_pair   = last;
    return p;
  endfunction

  // Pair within +/- span, half of the time placed close together and possibly
  // one box length apart so that the wrap brings it back into range.
  function automatic pair_t make_pair(int unsigned span, int unsigned cut_max, bit last);
    pair_t  p;
    longint a;
    longint b;
    longint off;
    longint shift;
    bit     near;
    p.cutoff      = LEN_W'($urandom_range(0, cut_max));
    p.list_select = 1'($urandom_range(0, 1));
    p.last_pair   = last;
    near          = 1'($urandom_range(0, 1));
    for (int k = 0; k < NUM_AXES; k++) begin
      a = longint'($urandom_range(0, 2 * span)) - longint'(span);
      if (near) begin
        off   = longint'($urandom_range(0, p.cutoff)) - longint'(p.cutoff >> 1);
        shift = longint'(box_len[k]) * (longint'($urandom_range(0, 2)) - 1);
        b     = a - off + shift;
      end else begin
        b = longint'($urandom_range(0, 2 * span)) - longint'(span);
      end
      p.pos_a[k] = a[POS_W-1:0];
      p.pos_b[k] = b[POS_W-1:0];
    end
    return p;
  endfunction

  // Fully random fields, including lone last flags that cut lists short.
  function automatic pair_t noise_pair();
    pair_t p;
    for (int k = 0; k < NUM_AXES; k++) begin
      p.pos_a[k] = $urandom;
      p.pos_b[k] = $urandom;
    end
    p.cutoff      = LEN_W'($urandom);
    p.list_select = 1'($urandom_range(0, 1));
    p.last_pair   = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  // Send one pair transaction, with an optional idle gap before it.
  task automatic send_pair(pair_t p);
    int unsigned gap;
    gap = (src_gaps_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      pair_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pair_if.first_x     <= p.pos_a[0];
    pair_if.first_y     <= p.pos_a[1];
    pair_if.first_z     <= p.pos_a[2];
    pair_if.second_x    <= p.pos_b[0];
    pair_if.second_y    <= p.pos_b[1];
    pair_if.second_z    <= p.pos_b[2];
    pair_if.cutoff      <= p.cutoff;
    pair_if.list_select <= p.list_select;
    pair_if.last_pair   <= p.last_pair;
    pair_if.valid       <= 1'b1;
    do @(posedge clk); while (pair_if.ready !== 1'b1);
    predict_contact(p);
  endtask

  // Stop sending and wait until every queued result has come back.
  task automatic wait_idle();
    @(negedge clk);
    pair_if.valid <= 1'b0;
    while (expected_contacts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(pcc_pkg::cfg_idx_t idx, bit [LEN_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  // Program all six box registers while the block is idle.
  task automatic load_box(axis_len_t box, axis_len_t half);
    wait_idle();
    write_reg(pcc_pkg::CFG_BOX_X, box[0]);
    write_reg(pcc_pkg::CFG_BOX_Y, box[1]);
    write_reg(pcc_pkg::CFG_BOX_Z, box[2]);
    write_reg(pcc_pkg::CFG_HALF_X, half[0]);
    write_reg(pcc_pkg::CFG_HALF_Y, half[1]);
    write_reg(pcc_pkg::CFG_HALF_Z, half[2]);
    @(negedge clk);
    cfg_we   <= 1'b0;
    box_len  = box;
    half_len = half;
  endtask

  // Random lists; some of them run without any idling on either side.
  task automatic run_lists(int unsigned n_items, int unsigned span, int unsigned cut_max);
    int unsigned sent;
    int unsigned len;
    bit          quiet;
    pair_t       p;
    sent = 0;
    while (sent < n_items) begin
      len            = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 150)
                                                   : $urandom_range(1, 40);
      quiet          = ($urandom_range(0, 4) == 0);
      src_gaps_on    = !quiet;
      sink_stalls_on = !quiet;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          p = noise_pair();
        end else begin
          p = make_pair(span, cut_max, i == len - 1);
        end
        send_pair(p);
      end
      sent += len;
    end
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // Registers still at their reset value of zero: no wrap ever shortens a distance.
  task automatic test_reset_values();
    send_pair(make_fixed(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_fixed(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN,
                         LEN_MAX, 1, 0));
    send_pair(make_fixed(POS_MIN, 0, 0, POS_MAX, 0, 0, LEN_MAX, 0, 1));
    send_pair(make_fixed(1, 0, 0, 0, 0, 0, 1, 1, 1));
    send_pair(make_fixed(0, 0, 0, 0, 0, 0, 0, 0, 1));
  endtask

  // Wrap thresholds hit exactly and by one, a distance equal to the cutoff,
  // and a change of list select inside one list.
  task automatic test_minimum_image();
    int h;
    int b;
    h = 5 * ONE;
    b = 10 * ONE;
    load_box('{LEN_W'(b), LEN_W'(b), LEN_W'(b)}, '{LEN_W'(h), LEN_W'(h), LEN_W'(h)});
    send_pair(make_fixed(h, 0, 0, 0, 0, 0, h, 0, 0));
    send_pair(make_fixed(h + 1, 0, 0, 0, 0, 0, h - 1, 1, 0));
    send_pair(make_fixed(0, 0, 0, h, 0, 0, h - 1, 0, 0));
    send_pair(make_fixed(0, 0, 0, h + 1, 0, 0, h - 1, 1, 0));
    send_pair(make_fixed(0, 9 * ONE, 0, 0, 0, 9 * ONE, 2 * ONE, 0, 0));
    send_pair(make_fixed(3 * ONE, 4 * ONE, 0, 0, 0, 0, 5 * ONE, 0, 0));
    send_pair(make_fixed(3 * ONE, 4 * ONE, 0, 0, 0, 0, 5 * ONE - 1, 1, 0));
    send_pair(make_fixed(POS_MAX, POS_MIN, 0, POS_MIN, POS_MAX, 0, LEN_MAX, 0, 1));
  endtask

  // Largest box: differences wider than 32 bits and squares near 2^62.
  task automatic test_wide_differences();
    load_box('{LEN_W'(LEN_MAX), LEN_W'(LEN_MAX), LEN_W'(LEN_MAX)},
             '{LEN_W'(LEN_MAX), LEN_W'(LEN_MAX), LEN_W'(LEN_MAX)});
    send_pair(make_fixed(POS_MAX, 0, 0, POS_MIN, 0, 0, LEN_MAX, 1, 0));
    send_pair(make_fixed(POS_MAX, 0, 0, 0, 0, 0, LEN_MAX, 0, 0));
    send_pair(make_fixed(0, POS_MIN, 0, 0, 0, 0, LEN_MAX, 1, 0));
    send_pair(make_fixed(POS_MAX, POS_MAX, POS_MAX, 0, 0, 0, LEN_MAX, 0, 1));
    // A zero half length wraps every nonzero difference.
    load_box('{LEN_W'(LEN_MAX), LEN_W'(LEN_MAX), LEN_W'(LEN_MAX)}, '{0, 0, 0});
    send_pair(make_fixed(1, 0, 0, 0, 0, 0, LEN_MAX, 0, 0));
    send_pair(make_fixed(0, 0, 0, 0, 0, 1, LEN_MAX - 2, 1, 0));
    send_pair(make_fixed(0, 0, 0, 0, 0, 0, 0, 1, 1));
  endtask

  // One long list of back-to-back contacts climbs the count, then restarts.
  task automatic test_count_saturation();
    load_box('{0, 0, 0}, '{0, 0, 0});
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (60) send_pair(make_fixed(0, 0, 0, 0, 0, 0, 0,
                                     1'($urandom_range(0, 1)), 0));
    send_pair(make_fixed(0, 0, 0, 0, 0, 0, 0, 1, 1));
    send_pair(make_fixed(0, 0, 0, 0, 0, 0, 0, 0, 1));
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // Random lists under several box settings, the extremes among them.
  task automatic test_random_traffic();
    axis_len_t   box;
    axis_len_t   half;
    int unsigned span;
    int unsigned cut_max;
    for (int phase = 0; phase < 6; phase++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        case (phase)
          0: begin
            box[k]  = LEN_W'($urandom_range(ONE, 64 * ONE));
            half[k] = box[k] >> 1;
          end
          1: begin
            box[k]  = LEN_W'($urandom_range(16, 4 * ONE));
            half[k] = box[k] >> 1;
          end
          2: begin
            box[k]  = LEN_W'($urandom_range(ONE, 64 * ONE));
            half[k] = LEN_W'($urandom_range(0, 64 * ONE));
          end
          3: begin
            box[k]  = LEN_W'(LEN_MAX);
            half[k] = LEN_W'(LEN_MAX);
          end
          4: begin
            box[k]  = LEN_W'(LEN_MAX);
            half[k] = '0;
          end
          default: begin
            box[k]  = '0;
            half[k] = '0;
          end
        endcase
      end
      case (phase)
        0, 2: begin
          span    = 64 * ONE;
          cut_max = 16 * ONE;
        end
        1: begin
          span    = 4 * ONE;
          cut_max = ONE;
        end
        3: begin
          span    = 1 << 29;
          cut_max = 1 << 30;
        end
        4: begin
          span    = 1 << 29;
          cut_max = LEN_MAX;
        end
        default: begin
          span    = 16 * ONE;
          cut_max = 8 * ONE;
        end
      endcase
      load_box(box, half);
      run_lists(300, span, cut_max);
    end
  endtask

  // Result channel back-pressure.
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (sink_stalls_on && $urandom_range(0, 7) == 0) stall_left = gap_len();
      end
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got_result.contact_made  = res_if.contact_made;
      got_result.contact_count = res_if.contact_count;
      got_result.list_echo     = res_if.list_echo;
      got_result.last_result   = res_if.last_result;
      if (expected_contacts.size() == 0) begin
        $error("result transaction with no expected result pending");
        mismatches++;
      end else begin
        want_result = expected_contacts.pop_front();
        if (got_result.contact_made !== want_result.contact_made) begin
          $error("contact_made mismatch: expected %0d, actual %0d",
                 want_result.contact_made, got_result.contact_made);
          mismatches++;
        end
        if (got_result.contact_count !== want_result.contact_count) begin
          $error("contact_count mismatch: expected %0d, actual %0d",
                 want_result.contact_count, got_result.contact_count);
          mismatches++;
        end
        if (got_result.list_echo !== want_result.list_echo) begin
          $error("list_echo mismatch: expected %0d, actual %0d",
                 want_result.list_echo, got_result.list_echo);
          mismatches++;
        end
        if (got_result.last_result !== want_result.last_result) begin
          $error("last_result mismatch: expected %0d, actual %0d",
                 want_result.last_result, got_result.last_result);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any transaction ends the run.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((pair_if.valid === 1'b1 && pair_if.ready === 1'b1) ||
          (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence.
  initial begin
    mismatches          = 0;
    list_total          = 0;
    src_gaps_on         = 1'b1;
    sink_stalls_on      = 1'b1;
    box_len             = '{0, 0, 0};
    half_len            = '{0, 0, 0};
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = pcc_pkg::CFG_BOX_X;
    cfg_data            = '0;
    pair_if.valid       = 1'b0;
    pair_if.first_x     = '0;
    pair_if.first_y     = '0;
    pair_if.first_z     = '0;
    pair_if.second_x    = '0;
    pair_if.second_y    = '0;
    pair_if.second_z    = '0;
    pair_if.cutoff      = '0;
    pair_if.list_select = 1'b0;
    pair_if.last_pair   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_minimum_image();
    test_wide_differences();
    test_count_saturation();
    test_random_traffic();

    wait_idle();
    repeat (LATENCY * 3) @(posedge clk);
    if (expected_contacts.size() != 0) begin
      $error("%0d expected results never arrived", expected_contacts.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
